// ===== hw/rtl/bbtc_pkg.sv =====
// Package for the advertisement type classifier: item structs, verdict codes,
// structure type codes and the door sensor name table. No dependencies.
`default_nettype none

package bbtc_pkg;

  localparam int AdvMaxBytes = 31;

  localparam logic [7:0] TypeMfg    = 8'hFF;
  localparam logic [7:0] TypeSvc    = 8'h16;
  localparam logic [7:0] TypeUuid16 = 8'h03;
  localparam logic [7:0] TypeName   = 8'h09;

  localparam int SeenMfg  = 0;
  localparam int SeenSvc  = 1;
  localparam int SeenUuid = 2;
  localparam int SeenName = 3;

  localparam logic [15:0] CompanyId   = 16'h004C;
  localparam logic [15:0] MfgBeaconId = 16'h1502;
  localparam logic [15:0] SvcBeaconId = 16'hFEAA;
  localparam logic [15:0] SensorId    = 16'hFE95;
  localparam logic [15:0] ThermoId    = 16'h181A;

  localparam logic [7:0] FrameCodeUid = 8'h00;
  localparam logic [7:0] FrameCodeUrl = 8'h10;
  localparam logic [7:0] FrameCodeTlm = 8'h20;

  typedef enum logic [2:0] {
    KindNone    = 3'd0,
    KindMfg     = 3'd1,
    KindService = 3'd2,
    KindSensor  = 3'd3,
    KindDoor    = 3'd4,
    KindThermo  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    FrameUid  = 2'd0,
    FrameUrl  = 2'd1,
    FrameTlm  = 2'd2,
    FrameNone = 2'd3
  } frame_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } bbtc_in_t;

  typedef struct packed {
    logic [2:0] broadcaster_kind;
    logic [1:0] service_frame_kind;
  } bbtc_out_t;

  function automatic logic [7:0] door_name_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:  b = 8'h42;
      4'd1:  b = 8'h65;
      4'd2:  b = 8'h65;
      4'd3:  b = 8'h57;
      4'd4:  b = 8'h69;
      4'd5:  b = 8'h20;
      4'd6:  b = 8'h53;
      4'd7:  b = 8'h6D;
      4'd8:  b = 8'h61;
      4'd9:  b = 8'h72;
      4'd10: b = 8'h74;
      4'd11: b = 8'h20;
      4'd12: b = 8'h44;
      4'd13: b = 8'h6F;
      4'd14: b = 8'h6F;
      4'd15: b = 8'h72;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ble_beacon_type_classifier_unit.sv =====
// Advertisement type classifier top level: LTV walk, capture and verdict.
// Depends on bbtc_pkg.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_item_i  (data_byte, last_byte)
//   out     | output    | out_valid_o/out_ready_i| out_item_o (broadcaster_kind, frame)
//
// One item per cycle; the walk state updates at the accepting edge.
// The verdict for a last byte is registered in the result register when that byte is accepted.
// Walk state returns to its reset values after each last byte.
// in_ready_o drops only while a result waits and out_ready_i is low.
`default_nettype none

module ble_beacon_type_classifier_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  bbtc_pkg::bbtc_in_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output bbtc_pkg::bbtc_out_t  out_item_o
);
  import bbtc_pkg::*;

  logic [7:0]  remaining_q, remaining_w, remaining_d;
  logic [7:0]  type_q, type_w, type_d;
  logic [7:0]  offset_q, offset_w, offset_d;
  logic        stopped_q, stopped_w, stopped_d;
  logic [3:0]  seen_q, seen_w, seen_d;
  logic [7:0]  mfg_len_q, mfg_len_w, mfg_len_d;
  logic [31:0] mfg_head_q, mfg_head_w, mfg_head_d;
  logic [7:0]  svc_len_q, svc_len_w, svc_len_d;
  logic [31:0] svc_head_q, svc_head_w, svc_head_d;
  logic [7:0]  uuid_len_q, uuid_len_w, uuid_len_d;
  logic [15:0] uuid_val_q, uuid_val_w, uuid_val_d;
  logic [7:0]  name_len_q, name_len_w, name_len_d;
  logic        name_ok_q, name_ok_w, name_ok_d;
  logic [7:0]  byte_pos_q, byte_pos_d;

  logic        out_valid_q, out_valid_d;
  bbtc_out_t   out_item_q;
  bbtc_out_t   verdict;

  logic        in_acc;
  logic        last;
  logic [7:0]  b;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign b           = in_item_i.data_byte;
  assign last        = in_item_i.last_byte;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // structure walk for the current byte
  always_comb begin
    logic [7:0] d;
    logic [7:0] rem_n;
    logic [4:0] sh;
    d     = offset_q - 8'd1;
    rem_n = remaining_q - 8'd1;
    sh    = {d[1:0], 3'b000};
    remaining_w = remaining_q;
    type_w      = type_q;
    offset_w    = offset_q;
    stopped_w   = stopped_q;
    seen_w      = seen_q;
    mfg_len_w   = mfg_len_q;
    mfg_head_w  = mfg_head_q;
    svc_len_w   = svc_len_q;
    svc_head_w  = svc_head_q;
    uuid_len_w  = uuid_len_q;
    uuid_val_w  = uuid_val_q;
    name_len_w  = name_len_q;
    name_ok_w   = name_ok_q;
    if (!stopped_q && (byte_pos_q < 8'(AdvMaxBytes))) begin
      if (remaining_q == 8'd0) begin
        if (b == 8'd0) begin
          stopped_w = 1'b1;
        end else begin
          remaining_w = b;
          offset_w    = 8'd0;
        end
      end else begin
        if (offset_q == 8'd0) begin
          type_w = b;
        end else if (type_q == TypeMfg && !seen_q[SeenMfg]) begin
          if (d < 8'd4) mfg_head_w[sh +: 8] = mfg_head_q[sh +: 8] | b;
        end else if (type_q == TypeSvc && !seen_q[SeenSvc]) begin
          if (d < 8'd4) svc_head_w[sh +: 8] = svc_head_q[sh +: 8] | b;
        end else if (type_q == TypeUuid16 && !seen_q[SeenUuid]) begin
          if (d < 8'd2) uuid_val_w[sh[3:0] +: 8] = uuid_val_q[sh[3:0] +: 8] | b;
        end else if (type_q == TypeName && !seen_q[SeenName]) begin
          if (d < 8'd16 && b != door_name_byte(d[3:0])) name_ok_w = 1'b0;
        end
        offset_w    = offset_q + 8'd1;
        remaining_w = rem_n;
        // commit: data length equals the old offset
        if (rem_n == 8'd0) begin
          if (type_w == TypeMfg && !seen_q[SeenMfg]) begin
            seen_w[SeenMfg] = 1'b1;
            mfg_len_w       = offset_q;
          end else if (type_w == TypeSvc && !seen_q[SeenSvc]) begin
            seen_w[SeenSvc] = 1'b1;
            svc_len_w       = offset_q;
          end else if (type_w == TypeUuid16 && !seen_q[SeenUuid]) begin
            seen_w[SeenUuid] = 1'b1;
            uuid_len_w       = offset_q;
          end else if (type_w == TypeName && !seen_q[SeenName]) begin
            seen_w[SeenName] = 1'b1;
            name_len_w       = offset_q;
          end
        end
      end
    end
  end

  // verdict on the post-walk state
  always_comb begin
    logic [7:0] p;
    logic [7:0] ft;
    logic       svc_frame_ok;
    p  = svc_len_w - 8'd3;
    ft = svc_head_w[23:16];
    svc_frame_ok = seen_w[SeenUuid] && uuid_len_w == 8'd2 && uuid_val_w == SvcBeaconId &&
                   seen_w[SeenSvc] && svc_len_w >= 8'd3 && svc_head_w[15:0] == SvcBeaconId;
    verdict.broadcaster_kind   = KindNone;
    verdict.service_frame_kind = FrameNone;
    priority if (seen_w[SeenMfg] && mfg_len_w >= 8'd25 &&
                 mfg_head_w[15:0] == CompanyId && mfg_head_w[31:16] == MfgBeaconId) begin
      verdict.broadcaster_kind = KindMfg;
    end else if (svc_frame_ok && ft == FrameCodeUid && (p == 8'd19 || p == 8'd17)) begin
      verdict.broadcaster_kind   = KindService;
      verdict.service_frame_kind = FrameUid;
    end else if (svc_frame_ok && ft == FrameCodeUrl && p >= 8'd2) begin
      verdict.broadcaster_kind   = KindService;
      verdict.service_frame_kind = FrameUrl;
    end else if (svc_frame_ok && ft == FrameCodeTlm && p == 8'd13) begin
      verdict.broadcaster_kind   = KindService;
      verdict.service_frame_kind = FrameTlm;
    end else if (seen_w[SeenSvc] && svc_len_w >= 8'd13 &&
                 svc_head_w[15:0] == SensorId) begin
      verdict.broadcaster_kind = KindSensor;
    end else if (!(seen_w[SeenName] && name_len_w == 8'd16 && !name_ok_w) &&
                 seen_w[SeenMfg] && mfg_len_w == 8'd7) begin
      verdict.broadcaster_kind = KindDoor;
    end else if (seen_w[SeenSvc] && svc_len_w >= 8'd17 &&
                 svc_head_w[31:16] == ThermoId) begin
      verdict.broadcaster_kind = KindThermo;
    end
  end

  always_comb begin
    remaining_d = remaining_q;
    type_d      = type_q;
    offset_d    = offset_q;
    stopped_d   = stopped_q;
    seen_d      = seen_q;
    mfg_len_d   = mfg_len_q;
    mfg_head_d  = mfg_head_q;
    svc_len_d   = svc_len_q;
    svc_head_d  = svc_head_q;
    uuid_len_d  = uuid_len_q;
    uuid_val_d  = uuid_val_q;
    name_len_d  = name_len_q;
    name_ok_d   = name_ok_q;
    byte_pos_d  = byte_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_acc) begin
      if (last) begin
        remaining_d = '0;
        type_d      = '0;
        offset_d    = '0;
        stopped_d   = 1'b0;
        seen_d      = '0;
        mfg_len_d   = '0;
        mfg_head_d  = '0;
        svc_len_d   = '0;
        svc_head_d  = '0;
        uuid_len_d  = '0;
        uuid_val_d  = '0;
        name_len_d  = '0;
        name_ok_d   = 1'b1;
        byte_pos_d  = '0;
        out_valid_d = 1'b1;
      end else begin
        remaining_d = remaining_w;
        type_d      = type_w;
        offset_d    = offset_w;
        stopped_d   = stopped_w;
        seen_d      = seen_w;
        mfg_len_d   = mfg_len_w;
        mfg_head_d  = mfg_head_w;
        svc_len_d   = svc_len_w;
        svc_head_d  = svc_head_w;
        uuid_len_d  = uuid_len_w;
        uuid_val_d  = uuid_val_w;
        name_len_d  = name_len_w;
        name_ok_d   = name_ok_w;
        byte_pos_d  = (byte_pos_q == 8'hFF) ? byte_pos_q : byte_pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      type_q      <= '0;
      offset_q    <= '0;
      stopped_q   <= 1'b0;
      seen_q      <= '0;
      mfg_len_q   <= '0;
      mfg_head_q  <= '0;
      svc_len_q   <= '0;
      svc_head_q  <= '0;
      uuid_len_q  <= '0;
      uuid_val_q  <= '0;
      name_len_q  <= '0;
      name_ok_q   <= 1'b1;
      byte_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      type_q      <= type_d;
      offset_q    <= offset_d;
      stopped_q   <= stopped_d;
      seen_q      <= seen_d;
      mfg_len_q   <= mfg_len_d;
      mfg_head_q  <= mfg_head_d;
      svc_len_q   <= svc_len_d;
      svc_head_q  <= svc_head_d;
      uuid_len_q  <= uuid_len_d;
      uuid_val_q  <= uuid_val_d;
      name_len_q  <= name_len_d;
      name_ok_q   <= name_ok_d;
      byte_pos_q  <= byte_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last) begin
      out_item_q <= verdict;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last |=> out_valid_q)
    else $error("no result after last byte");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && last))
    else $error("result without last byte");

  a_walk_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last |=> remaining_q == 8'd0 && seen_q == 4'd0 && !stopped_q &&
                      byte_pos_q == 8'd0 && name_ok_q)
    else $error("walk state not cleared after last byte");

  a_frame_only_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.broadcaster_kind != KindService |->
      out_item_q.service_frame_kind == FrameNone)
    else $error("frame kind set for non-service verdict");

  a_stop_between_structs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remaining_q != 8'd0 |-> !stopped_q)
    else $error("walk stopped inside a structure");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for ble_beacon_type_classifier_unit: streams advertisement bytes over valid/ready,
// predicts the verdict of each advertisement and checks every result item in order.
// Depends on bbtc_pkg and the unit under test.
module testbench;
  import bbtc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ReportMax  = 10;
  localparam logic [7:0] TypeFlags = 8'h01;
  // door sensor name, byte 0 in the top bits
  localparam logic [127:0] DoorName = 128'h4265_6557_6920_536D_6172_7420_446F_6F72;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  bbtc_in_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  bbtc_out_t out_item_o;

  ble_beacon_type_classifier_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // walk and capture state of the predictor
  logic [7:0]  lt_left, lt_type, lt_offset;
  logic        walk_halted;
  logic [3:0]  kept;
  logic [7:0]  mfg_len, svc_len, uuid_len, name_len;
  logic [31:0] mfg_bytes, svc_bytes;
  logic [15:0] uuid_word;
  logic        name_same;
  int unsigned adv_pos;

  bbtc_out_t   verdict_q[$];
  bbtc_in_t    byte_q[$];
  logic [7:0]  adv_buf[$];
  bbtc_out_t   want;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_bytes, phase_advs;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic void restart_adv();
    lt_left = 8'd0;
    lt_type = 8'd0;
    lt_offset = 8'd0;
    walk_halted = 1'b0;
    kept = 4'd0;
    mfg_len = 8'd0;
    mfg_bytes = 32'd0;
    svc_len = 8'd0;
    svc_bytes = 32'd0;
    uuid_len = 8'd0;
    uuid_word = 16'd0;
    name_len = 8'd0;
    name_same = 1'b1;
    adv_pos = 0;
  endfunction

  function automatic bbtc_out_t classify();
    bbtc_out_t  v;
    logic [7:0] pay;
    v.broadcaster_kind = KindNone;
    v.service_frame_kind = FrameNone;
    pay = svc_len - 8'd3;
    if (kept[SeenMfg] && mfg_len >= 8'd25 && mfg_bytes[15:0] == CompanyId &&
        mfg_bytes[31:16] == MfgBeaconId) begin
      v.broadcaster_kind = KindMfg;
      return v;
    end
    if (kept[SeenUuid] && uuid_len == 8'd2 && uuid_word == SvcBeaconId &&
        kept[SeenSvc] && svc_len >= 8'd3 && svc_bytes[15:0] == SvcBeaconId) begin
      v.broadcaster_kind = KindService;
      if (svc_bytes[23:16] == FrameCodeUid && (pay == 8'd19 || pay == 8'd17)) begin
        v.service_frame_kind = FrameUid;
        return v;
      end
      if (svc_bytes[23:16] == FrameCodeUrl && pay >= 8'd2) begin
        v.service_frame_kind = FrameUrl;
        return v;
      end
      if (svc_bytes[23:16] == FrameCodeTlm && pay == 8'd13) begin
        v.service_frame_kind = FrameTlm;
        return v;
      end
      v.broadcaster_kind = KindNone;
    end
    if (kept[SeenSvc] && svc_len >= 8'd13 && svc_bytes[15:0] == SensorId) begin
      v.broadcaster_kind = KindSensor;
      return v;
    end
    if (!(kept[SeenName] && name_len == 8'd16 && !name_same) &&
        kept[SeenMfg] && mfg_len == 8'd7) begin
      v.broadcaster_kind = KindDoor;
      return v;
    end
    if (kept[SeenSvc] && svc_len >= 8'd17 && svc_bytes[31:16] == ThermoId)
      v.broadcaster_kind = KindThermo;
    return v;
  endfunction

  function automatic void adv_step(bbtc_in_t it);
    logic [7:0] b, d;
    b = it.data_byte;
    if (!walk_halted && adv_pos < AdvMaxBytes) begin
      if (lt_left == 8'd0) begin
        if (b == 8'd0) begin
          walk_halted = 1'b1;
        end else begin
          lt_left = b;
          lt_offset = 8'd0;
        end
      end else begin
        d = lt_offset - 8'd1;
        if (lt_offset == 8'd0) begin
          lt_type = b;
        end else if (lt_type == TypeMfg && !kept[SeenMfg]) begin
          if (d < 8'd4) mfg_bytes |= 32'(b) << (8 * d);
        end else if (lt_type == TypeSvc && !kept[SeenSvc]) begin
          if (d < 8'd4) svc_bytes |= 32'(b) << (8 * d);
        end else if (lt_type == TypeUuid16 && !kept[SeenUuid]) begin
          if (d < 8'd2) uuid_word |= 16'(b) << (8 * d);
        end else if (lt_type == TypeName && !kept[SeenName]) begin
          if (d < 8'd16 && b != DoorName[127 - 8 * d -: 8]) name_same = 1'b0;
        end
        lt_offset++;
        lt_left--;
        if (lt_left == 8'd0) begin
          if (lt_type == TypeMfg && !kept[SeenMfg]) begin
            kept[SeenMfg] = 1'b1;
            mfg_len = lt_offset - 8'd1;
          end else if (lt_type == TypeSvc && !kept[SeenSvc]) begin
            kept[SeenSvc] = 1'b1;
            svc_len = lt_offset - 8'd1;
          end else if (lt_type == TypeUuid16 && !kept[SeenUuid]) begin
            kept[SeenUuid] = 1'b1;
            uuid_len = lt_offset - 8'd1;
          end else if (lt_type == TypeName && !kept[SeenName]) begin
            kept[SeenName] = 1'b1;
            name_len = lt_offset - 8'd1;
          end
        end
      end
    end
    adv_pos++;
    if (it.last_byte) begin
      verdict_q.push_back(classify());
      restart_adv();
    end
  endfunction

  function automatic void put(logic [7:0] b);
    adv_buf.push_back(b);
  endfunction

  function automatic void put_rand(int unsigned n);
    repeat (n) adv_buf.push_back(8'($urandom));
  endfunction

  function automatic void put_struct(logic [7:0] kind, int unsigned n);
    put(8'(n + 1));
    put(kind);
    put_rand(n);
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(4))
      0: return TypeMfg;
      1: return TypeSvc;
      2: return TypeUuid16;
      3: return TypeName;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void flush_adv();
    bbtc_in_t it;
    if (adv_buf.size() == 0) adv_buf.push_back(8'($urandom));
    foreach (adv_buf[k]) begin
      it.data_byte = adv_buf[k];
      it.last_byte = (k == adv_buf.size() - 1);
      byte_q.push_back(it);
    end
    phase_bytes += adv_buf.size();
    phase_advs++;
    adv_buf.delete();
  endfunction

  // byte driver, predicts on every accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) adv_step(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i <= byte_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= ReportMax)
            $display("unexpected verdict: kind=%0d frame=%0d",
                     out_item_o.broadcaster_kind, out_item_o.service_frame_kind);
        end else begin
          want = verdict_q.pop_front();
          if (out_item_o.broadcaster_kind !== want.broadcaster_kind ||
              out_item_o.service_frame_kind !== want.service_frame_kind) begin
            fail_cnt++;
            if (fail_cnt <= ReportMax)
              $display("verdict mismatch: expected kind=%0d frame=%0d, got kind=%0d frame=%0d",
                       want.broadcaster_kind, want.service_frame_kind,
                       out_item_o.broadcaster_kind, out_item_o.service_frame_kind);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[ble_beacon_type_classifier_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned sel, n, trunc;
    logic [7:0]  fr;
    restart_adv();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero length at once, lone length byte, short door, type-only structures
    put(8'h00);
    flush_adv();
    put(8'hFF);
    flush_adv();
    put(8'd8);
    put(TypeMfg);
    repeat (3) begin
      put(8'h00);
      put(8'hFF);
    end
    put(8'h00);
    flush_adv();
    put(8'd1);
    put(TypeMfg);
    put(8'd1);
    put(TypeSvc);
    put(8'd1);
    put(TypeUuid16);
    put(8'd1);
    put(TypeName);
    flush_adv();
    // walk stopped before a structure, then a cut-off structure
    put(8'h00);
    put(8'd2);
    put(TypeMfg);
    put(8'h7F);
    flush_adv();
    put(8'd3);
    put(TypeSvc);
    put(SensorId[7:0]);
    flush_adv();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      phase_bytes = 0;
      phase_advs = 0;
      while (phase_bytes < 100 || phase_advs < 4) begin
        sel = $urandom_range(7);
        if ($urandom_range(3) == 0) put_struct(pick_type(), $urandom_range(3));
        case (sel)
          0: begin
            n = $urandom_range(23, 27);
            put(8'(n + 1));
            put(TypeMfg);
            put(CompanyId[7:0]);
            put(CompanyId[15:8]);
            put(MfgBeaconId[7:0]);
            put(MfgBeaconId[15:8]);
            put_rand(n - 4);
          end
          1: begin
            if ($urandom_range(1) != 0) begin
              put(8'd2);
              put(TypeFlags);
              put(8'h06);
            end
            if ($urandom_range(4) != 0) begin
              put(8'd3);
              put(TypeUuid16);
              put(SvcBeaconId[7:0]);
              put(SvcBeaconId[15:8]);
            end else begin
              put_struct(TypeUuid16, $urandom_range(4));
            end
            case ($urandom_range(3))
              0: begin fr = FrameCodeUid; n = ($urandom_range(1) != 0) ? 17 : 19; end
              1: begin fr = FrameCodeUrl; n = $urandom_range(14); end
              2: begin fr = FrameCodeTlm; n = 13; end
              default: begin fr = 8'($urandom); n = $urandom_range(19); end
            endcase
            if ($urandom_range(3) == 0) n = $urandom_range(20);
            put(8'(n + 4));
            put(TypeSvc);
            put(SvcBeaconId[7:0]);
            put(SvcBeaconId[15:8]);
            put(fr);
            put_rand(n);
          end
          2: begin
            n = $urandom_range(11, 20);
            put(8'(n + 1));
            put(TypeSvc);
            put(SensorId[7:0]);
            put(SensorId[15:8]);
            put_rand(n - 2);
          end
          3: begin
            if ($urandom_range(2) != 0) begin
              put(8'd17);
              put(TypeName);
              for (int k = 0; k < 16; k++) put(DoorName[127 - 8 * k -: 8]);
              if ($urandom_range(2) == 0) begin
                n = adv_buf.size() - 1 - $urandom_range(15);
                adv_buf[n] = adv_buf[n] ^ 8'h20;
              end
            end else begin
              put_struct(TypeName, $urandom_range(18));
            end
            put_struct(TypeMfg, ($urandom_range(3) != 0) ? 7 : $urandom_range(4, 10));
          end
          4: begin
            n = $urandom_range(15, 22);
            put(8'(n + 1));
            put(TypeSvc);
            put_rand(2);
            put(ThermoId[7:0]);
            put(ThermoId[15:8]);
            put_rand(n - 4);
          end
          5: begin
            repeat ($urandom_range(1, 5)) put_struct(pick_type(), $urandom_range(8));
            if ($urandom_range(4) == 0) put(8'h00);
          end
          6: begin
            put_rand($urandom_range(1, 40));
          end
          default: begin
            // door data next to service data: priority between verdicts
            put_struct(TypeMfg, 7);
            put(8'd18);
            put(TypeSvc);
            if ($urandom_range(1) != 0) begin
              put(SensorId[7:0]);
              put(SensorId[15:8]);
            end else begin
              put_rand(2);
            end
            put(ThermoId[7:0]);
            put(ThermoId[15:8]);
            put_rand(13);
          end
        endcase
        if ($urandom_range(5) == 0) begin
          n = $urandom_range(adv_buf.size() - 1);
          adv_buf[n] = adv_buf[n] ^ (8'd1 << $urandom_range(7));
        end
        if ($urandom_range(7) == 0) begin
          trunc = $urandom_range(adv_buf.size() - 1);
          repeat (trunc) void'(adv_buf.pop_back());
        end
        if ($urandom_range(3) == 0) begin
          put_rand($urandom_range(1, 8));
        end else if ($urandom_range(7) == 0) begin
          put(8'h00);
          put_rand($urandom_range(4));
        end
        flush_adv();
      end
      while (byte_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(negedge clk_i);
    end

    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ble_beacon_type_classifier_unit] OK");
    end else begin
      $display("[ble_beacon_type_classifier_unit] ERROR");
    end
    $finish;
  end

endmodule
